// ===== src/twcw_pkg.sv =====
// shared types and constants for the text window cursor writer
package twcw_pkg;

    localparam int WINDOWS     = 16;
    localparam int COLUMNS     = 32;
    localparam int ROWS        = 24;
    localparam int WIN_W       = 4;
    localparam int COL_W       = $clog2(COLUMNS + 1);
    localparam int ROW_W       = $clog2(ROWS + 1);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CHAR_TAB   = 8'd9;
    localparam logic [7:0] CHAR_NL    = 8'd10;
    localparam logic [7:0] CHAR_PCT   = 8'd37;
    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_THREE = 8'd51;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_FLUSH = 1'b1;

    typedef enum logic [2:0] {
        K_NEWLINE,
        K_TAB,
        K_PERCENT,
        K_DIGIT,
        K_OTHER
    } kind_t;

    typedef enum logic {
        PH_PEND,
        PH_MAIN
    } phase_t;

    typedef struct packed {
        logic [WIN_W-1:0] window;
        logic [7:0]       character;
        logic             eos;
        kind_t            kind;
    } cmd_t;

endpackage

// ===== src/twcw_front.sv =====
// front end: classifies incoming characters and queues them as commands
module twcw_front (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [twcw_pkg::WIN_W-1:0] s_window,
    input  logic [7:0]                s_character,
    input  logic                      s_end_of_string,
    output logic                      cmd_valid,
    output twcw_pkg::cmd_t            cmd,
    input  logic                      cmd_pop
);

    twcw_pkg::cmd_t                   queue_reg [twcw_pkg::QUEUE_DEPTH];
    logic [twcw_pkg::QPTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [twcw_pkg::QPTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [twcw_pkg::QCNT_W-1:0]      count_reg, count_next;
    twcw_pkg::cmd_t                   in_cmd;
    logic                             push;
    logic                             pop;

    always_comb begin
        in_cmd.window    = s_window;
        in_cmd.character = s_character;
        in_cmd.eos       = s_end_of_string;
        unique case (s_character) inside
            twcw_pkg::CHAR_NL:                          in_cmd.kind = twcw_pkg::K_NEWLINE;
            twcw_pkg::CHAR_TAB:                         in_cmd.kind = twcw_pkg::K_TAB;
            twcw_pkg::CHAR_PCT:                         in_cmd.kind = twcw_pkg::K_PERCENT;
            [twcw_pkg::CHAR_ZERO:twcw_pkg::CHAR_THREE]: in_cmd.kind = twcw_pkg::K_DIGIT;
            default:                                    in_cmd.kind = twcw_pkg::K_OTHER;
        endcase
    end

    assign s_ready   = (count_reg != twcw_pkg::QCNT_W'(twcw_pkg::QUEUE_DEPTH));
    assign push      = s_valid && s_ready;
    assign cmd_valid = (count_reg != '0);
    assign pop       = cmd_pop && cmd_valid;
    assign cmd       = queue_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            queue_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

// ===== src/twcw_back.sv =====
// back end: per-window cursor state, action sequencer and output register
module twcw_back (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cmd_valid,
    input  twcw_pkg::cmd_t             cmd,
    output logic                       cmd_pop,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic                       m_action,
    output logic [twcw_pkg::WIN_W-1:0] m_target_window,
    output logic                       m_scroll_first,
    output logic [4:0]                 m_column,
    output logic [15:0]                m_tile,
    output logic [4:0]                 m_row,
    output logic [5:0]                 m_line_length,
    output logic                       m_last_of_run
);

    function automatic logic [15:0] tile_of(input logic [7:0] c, input logic [1:0] colour);
        tile_of = {8'h00, c} - 16'd32 + {7'h00, colour, 7'h00};
    endfunction

    logic [twcw_pkg::COL_W-1:0] col_reg    [twcw_pkg::WINDOWS];
    logic [twcw_pkg::ROW_W-1:0] row_reg    [twcw_pkg::WINDOWS];
    logic [1:0]                 colour_reg [twcw_pkg::WINDOWS];
    logic                       pend_reg   [twcw_pkg::WINDOWS];

    twcw_pkg::phase_t           phase_reg, phase_next;

    logic [twcw_pkg::COL_W-1:0] col, col_next, col_inc;
    logic [twcw_pkg::ROW_W-1:0] row, row_next;
    logic [1:0]                 colour, colour_next;
    logic                       pend, pend_next;
    logic                       full;
    logic                       fl_scr;
    logic [twcw_pkg::ROW_W-1:0] fl_row, fl_row_next;

    logic                       emit, done, stay;
    logic                       o_action, o_scroll, o_last;
    logic [4:0]                 o_col, o_row;
    logic [15:0]                o_tile;
    logic [5:0]                 o_len;
    logic                       out_free, step;

    logic                       m_valid_reg, m_valid_next;
    logic                       m_action_reg;
    logic [twcw_pkg::WIN_W-1:0] m_window_reg;
    logic                       m_scroll_reg;
    logic [4:0]                 m_column_reg;
    logic [15:0]                m_tile_reg;
    logic [4:0]                 m_row_reg;
    logic [5:0]                 m_len_reg;
    logic                       m_last_reg;

    assign col     = col_reg[cmd.window];
    assign row     = row_reg[cmd.window];
    assign colour  = colour_reg[cmd.window];
    assign pend    = pend_reg[cmd.window];
    assign full    = (col == twcw_pkg::COL_W'(twcw_pkg::COLUMNS));
    assign col_inc = col + 1'b1;
    assign fl_scr  = (row >= twcw_pkg::ROW_W'(twcw_pkg::ROWS));
    assign fl_row      = fl_scr ? twcw_pkg::ROW_W'(twcw_pkg::ROWS - 1) : row;
    assign fl_row_next = fl_scr ? twcw_pkg::ROW_W'(twcw_pkg::ROWS) : row + 1'b1;

    assign out_free = !m_valid_reg || m_ready;
    assign step     = cmd_valid && out_free;
    assign cmd_pop  = step && done;

    // per-cycle action and state update
    always_comb begin
        emit        = 1'b0;
        done        = 1'b0;
        stay        = 1'b0;
        o_action    = twcw_pkg::ACT_WRITE;
        o_scroll    = 1'b0;
        o_col       = '0;
        o_tile      = '0;
        o_row       = '0;
        o_len       = '0;
        o_last      = 1'b0;
        col_next    = col;
        row_next    = row;
        colour_next = colour;
        pend_next   = pend;
        if (phase_reg == twcw_pkg::PH_PEND && (full || pend)) begin
            if (full) begin
                emit     = 1'b1;
                o_action = twcw_pkg::ACT_FLUSH;
                o_scroll = fl_scr;
                o_row    = 5'(fl_row);
                o_len    = 6'(col);
                col_next = '0;
                row_next = fl_row_next;
                o_last   = pend ? (cmd.kind == twcw_pkg::K_DIGIT)
                                : (cmd.kind == twcw_pkg::K_PERCENT && !cmd.eos);
                done     = o_last;
                stay     = !o_last;
                if (pend && cmd.kind == twcw_pkg::K_DIGIT) begin
                    colour_next = cmd.character[1:0];
                    pend_next   = 1'b0;
                end else if (!pend && o_last) begin
                    pend_next = 1'b1;
                end
            end else if (cmd.kind == twcw_pkg::K_DIGIT) begin
                colour_next = cmd.character[1:0];
                pend_next   = 1'b0;
                done        = 1'b1;
            end else begin
                emit     = 1'b1;
                o_col    = 5'(col);
                o_tile   = tile_of(twcw_pkg::CHAR_PCT, colour);
                col_next = col_inc;
                if (cmd.kind == twcw_pkg::K_PERCENT && !cmd.eos) begin
                    o_last = 1'b1;
                    done   = 1'b1;
                end else begin
                    pend_next = 1'b0;
                end
            end
        end else begin
            if (full || cmd.kind == twcw_pkg::K_NEWLINE) begin
                if (cmd.kind == twcw_pkg::K_PERCENT && !cmd.eos) begin
                    pend_next = 1'b1;
                    done      = 1'b1;
                end else begin
                    emit     = 1'b1;
                    o_action = twcw_pkg::ACT_FLUSH;
                    o_scroll = fl_scr;
                    o_row    = 5'(fl_row);
                    o_len    = 6'(col);
                    col_next = '0;
                    row_next = fl_row_next;
                    o_last   = !full;
                    done     = !full;
                end
            end else begin
                case (cmd.kind)
                    twcw_pkg::K_TAB: begin
                        emit     = 1'b1;
                        o_col    = 5'(col);
                        col_next = col_inc;
                        o_last   = (col_inc[1:0] == 2'b00)
                                || (col_inc == twcw_pkg::COL_W'(twcw_pkg::COLUMNS));
                        done     = o_last;
                    end
                    twcw_pkg::K_PERCENT: begin
                        if (cmd.eos) begin
                            emit     = 1'b1;
                            o_col    = 5'(col);
                            o_tile   = tile_of(twcw_pkg::CHAR_PCT, colour);
                            col_next = col_inc;
                            o_last   = 1'b1;
                        end else begin
                            pend_next = 1'b1;
                        end
                        done = 1'b1;
                    end
                    default: begin
                        emit     = 1'b1;
                        o_col    = 5'(col);
                        o_tile   = tile_of(cmd.character, colour);
                        col_next = col_inc;
                        o_last   = 1'b1;
                        done     = 1'b1;
                    end
                endcase
            end
        end
    end

    always_comb begin
        phase_next = phase_reg;
        if (step) begin
            if (done) begin
                phase_next = twcw_pkg::PH_PEND;
            end else if (!stay) begin
                phase_next = twcw_pkg::PH_MAIN;
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (step && emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= twcw_pkg::PH_PEND;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < twcw_pkg::WINDOWS; i++) begin
                col_reg[i]    <= '0;
                row_reg[i]    <= '0;
                colour_reg[i] <= '0;
                pend_reg[i]   <= 1'b0;
            end
        end else begin
            phase_reg   <= phase_next;
            m_valid_reg <= m_valid_next;
            if (step) begin
                col_reg[cmd.window]    <= col_next;
                row_reg[cmd.window]    <= row_next;
                colour_reg[cmd.window] <= colour_next;
                pend_reg[cmd.window]   <= pend_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (step && emit) begin
            m_action_reg <= o_action;
            m_window_reg <= cmd.window;
            m_scroll_reg <= o_scroll;
            m_column_reg <= o_col;
            m_tile_reg   <= o_tile;
            m_row_reg    <= o_row;
            m_len_reg    <= o_len;
            m_last_reg   <= o_last;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_action        = m_action_reg;
    assign m_target_window = m_window_reg;
    assign m_scroll_first  = m_scroll_reg;
    assign m_column        = m_column_reg;
    assign m_tile          = m_tile_reg;
    assign m_row           = m_row_reg;
    assign m_line_length   = m_len_reg;
    assign m_last_of_run   = m_last_reg;

endmodule

// ===== src/text_window_cursor_writer_top.sv =====
// top level of the text window cursor writer
// path: an item goes through the command queue, then the output register, to its first action
// throughput: one action per cycle unless m_ready stalls it; an item causes none, one or more
// a two-entry command queue lets new items in while the action sequencer is busy or stalled
// reset: synchronous active-low aresetn empties the queue and output register
// and clears column, row, colour and pending-percent state of every window
module text_window_cursor_writer_top (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [twcw_pkg::WIN_W-1:0] s_window,
    input  logic [7:0]                 s_character,
    input  logic                       s_end_of_string,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic                       m_action,
    output logic [twcw_pkg::WIN_W-1:0] m_target_window,
    output logic                       m_scroll_first,
    output logic [4:0]                 m_column,
    output logic [15:0]                m_tile,
    output logic [4:0]                 m_row,
    output logic [5:0]                 m_line_length,
    output logic                       m_last_of_run
);

    logic           cmd_valid;
    twcw_pkg::cmd_t cmd;
    logic           cmd_pop;

    twcw_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_window        (s_window),
        .s_character     (s_character),
        .s_end_of_string (s_end_of_string),
        .cmd_valid       (cmd_valid),
        .cmd             (cmd),
        .cmd_pop         (cmd_pop)
    );

    twcw_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd_valid       (cmd_valid),
        .cmd             (cmd),
        .cmd_pop         (cmd_pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_action        (m_action),
        .m_target_window (m_target_window),
        .m_scroll_first  (m_scroll_first),
        .m_column        (m_column),
        .m_tile          (m_tile),
        .m_row           (m_row),
        .m_line_length   (m_line_length),
        .m_last_of_run   (m_last_of_run)
    );

endmodule

// ===== src/twcw_checker.sv =====
// port-level checks for the text window cursor writer
module twcw_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic                       m_action,
    input logic                       m_scroll_first,
    input logic [4:0]                 m_column,
    input logic [15:0]                m_tile,
    input logic [4:0]                 m_row,
    input logic [5:0]                 m_line_length
);

    // a stalled result transfer holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_tile) && $stable(m_action))
        else $error("result changed while stalled");

    a_write_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_action == twcw_pkg::ACT_WRITE |->
            !m_scroll_first && m_row == '0 && m_line_length == '0)
        else $error("write carries flush fields");

    a_flush_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_action == twcw_pkg::ACT_FLUSH |->
            m_column == '0 && m_tile == '0
            && m_line_length <= 6'(twcw_pkg::COLUMNS)
            && m_row < 5'(twcw_pkg::ROWS))
        else $error("flush fields out of range");

    a_scroll_row: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_scroll_first |-> m_row == 5'(twcw_pkg::ROWS - 1))
        else $error("scroll not on bottom row");

endmodule

bind text_window_cursor_writer_top twcw_checker u_twcw_checker (.*);
